// ===== rtl/core/pulse_rate_wind_speed_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pulse rate wind speed block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PULSE_RATE_WIND_SPEED_MACROS_SVH
`define PULSE_RATE_WIND_SPEED_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define PRWS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("prws check failed");
// expression must never be true outside reset
`define PRWS_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("prws forbidden condition seen");
`else
`define PRWS_ASSERT(lbl, clk, rst, prop)
`define PRWS_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== rtl/core/prws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prws_pkg
// Shared types and constants of the pulse rate wind speed block.
// ----------------------------------------------------------------------------
package prws_pkg;

   localparam int PCOUNT_W  = 16;
   localparam int SPEED_W   = 32;
   localparam int REG_W     = 32;
   localparam int CALM_W    = 31;
   localparam int CSR_IDX_W = 3;

   localparam logic [PCOUNT_W-1:0] PCOUNT_MAX = '1;
   localparam logic [SPEED_W-1:0]  SPEED_MAX  = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WINDOW = 3'd0,
      REG_SQUARE = 3'd1,
      REG_LINEAR = 3'd2,
      REG_OFFSET = 3'd3,
      REG_CALM   = 3'd4
   } reg_index_type;

   localparam logic [REG_W-1:0]         WINDOW_RST = 32'd10000000;
   localparam logic signed [REG_W-1:0]  SQUARE_RST = -32'sd3037;
   localparam logic signed [REG_W-1:0]  LINEAR_RST = 32'sd2325154;
   localparam logic signed [REG_W-1:0]  OFFSET_RST = 32'sd23580377;
   localparam logic [CALM_W-1:0]        CALM_RST   = 31'd25165824;

   typedef struct packed {
      logic signed [REG_W-1:0] square;
      logic signed [REG_W-1:0] linear;
      logic signed [REG_W-1:0] offset;
      logic [CALM_W-1:0]       calm;
   } coef_type;

   // queue between front and back
   localparam int QDEPTH = 2;

   // km/h = (18 * mps + 2) / 5: remainder from the nibble sum (16 is one
   // modulo five), then an exact divide by the inverse of five modulo 2^32
   localparam int                 KMPH_W    = 40;
   localparam int                 NIBBLES   = KMPH_W / 4;
   localparam logic [KMPH_W-1:0]  KMPH_OVER = 40'h5_0000_0000;
   localparam logic [SPEED_W-1:0] INV_FIVE  = 32'hCCCC_CCCD;

endpackage

// ===== rtl/core/pulse_rate_wind_speed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_rate_wind_speed
// Cup anemometer pulse counter with quadratic speed calibration.
// ----------------------------------------------------------------------------
// Input queue: push a beat carrying a microsecond tick and/or a rotor pulse
// edge while full is low; one beat is taken every cycle. Pulses are counted
// (held at the counter maximum) and ticks are counted; the tick that brings
// the elapsed count up to window_ticks closes the window, and a pulse on that
// beat counts in the next window.
// Result queue: each closed window yields one beat with the pulse count and
// the speed in m/s and km/h (unsigned Q8.24); it stays on the ports while
// empty is low until pop takes it.
// The speed sequencer steps through each window in turn: eight steps on one 33 by
// COUNT_WIDTH+1 multiplier and adders, four steps of the km/h conversion
// and one to hand the result over.
// A two-entry queue holds closed windows; if windows close faster than the
// sequencer finishes them, or the result is not popped, full rises and
// input stalls.
// Reset clears the counters, both queues and reloads the register defaults.
// Write registers through csr_we/csr_index/csr_wdata only while idle.
// ----------------------------------------------------------------------------
module pulse_rate_wind_speed #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_time_tick,
   input  logic                                  req_pulse_edge,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [prws_pkg::PCOUNT_W-1:0]         rsp_pulse_count,
   output logic [prws_pkg::SPEED_W-1:0]          rsp_speed_mps,
   output logic [prws_pkg::SPEED_W-1:0]          rsp_speed_kmph,
   input  logic                                  csr_we,
   input  logic [prws_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [prws_pkg::REG_W-1:0]            csr_wdata
);

   logic [prws_pkg::REG_W-1:0] window_ff;
   prws_pkg::coef_type         coef_ff;
   logic                       q_push;
   logic                       q_pop;
   logic                       q_full;
   logic                       q_empty;
   logic [COUNT_WIDTH-1:0]     q_count;
   logic [COUNT_WIDTH-1:0]     q_data;

   assign req_full = q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= prws_pkg::WINDOW_RST;
         coef_ff.square <= prws_pkg::SQUARE_RST;
         coef_ff.linear <= prws_pkg::LINEAR_RST;
         coef_ff.offset <= prws_pkg::OFFSET_RST;
         coef_ff.calm   <= prws_pkg::CALM_RST;
      end else if (csr_we) begin
         unique case (prws_pkg::reg_index_type'(csr_index))
            prws_pkg::REG_WINDOW: window_ff      <= csr_wdata;
            prws_pkg::REG_SQUARE: coef_ff.square <= csr_wdata;
            prws_pkg::REG_LINEAR: coef_ff.linear <= csr_wdata;
            prws_pkg::REG_OFFSET: coef_ff.offset <= csr_wdata;
            prws_pkg::REG_CALM:   coef_ff.calm   <= csr_wdata[prws_pkg::CALM_W-1:0];
            default: ;
         endcase
      end
   end

   prws_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_time_tick  (req_time_tick),
      .req_pulse_edge (req_pulse_edge),
      .window_ticks   (window_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_count        (q_count)
   );

   prws_queue #(
      .WIDTH (COUNT_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_count),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   prws_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .coef            (coef_ff),
      .q_empty         (q_empty),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pulse_count (rsp_pulse_count),
      .rsp_speed_mps   (rsp_speed_mps),
      .rsp_speed_kmph  (rsp_speed_kmph)
   );

endmodule

// ===== rtl/core/prws_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prws_queue
// Small first-in first-out store of closed-window pulse counts.
// ----------------------------------------------------------------------------
`include "pulse_rate_wind_speed_macros.svh"
module prws_queue #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(prws_pkg::QDEPTH);
   localparam int CNT_W = $clog2(prws_pkg::QDEPTH + 1);

   logic [WIDTH-1:0] mem_ff [prws_pkg::QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   assign full     = (cnt_ff == CNT_W'(prws_pkg::QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      priority if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PRWS_NEVER(a_q_overflow, clock, reset, push && full)
   `PRWS_NEVER(a_q_underflow, clock, reset, pop && empty)

endmodule

// ===== rtl/core/prws_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prws_front
// Takes tick and pulse beats, counts them and hands each closed window's
// pulse count to the queue.
// ----------------------------------------------------------------------------
module prws_front #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic                              req_time_tick,
   input  logic                              req_pulse_edge,
   input  logic [prws_pkg::REG_W-1:0]        window_ticks,
   input  logic                              q_full,
   output logic                              q_push,
   output logic [COUNT_WIDTH-1:0]            q_count
);

   logic [COUNT_WIDTH-1:0]     count_ff;
   logic [COUNT_WIDTH-1:0]     count_in;
   logic [prws_pkg::REG_W-1:0] elapsed_ff;
   logic [prws_pkg::REG_W-1:0] elapsed_in;
   logic [prws_pkg::REG_W-1:0] elapsed_inc;
   logic                       accept;
   logic                       close;

   assign accept      = req_push && !q_full;
   assign elapsed_inc = elapsed_ff + prws_pkg::REG_W'(1);
   assign close       = accept && req_time_tick && (elapsed_inc >= window_ticks);
   assign q_push      = close;
   assign q_count     = count_ff;

   always_comb begin
      count_in   = count_ff;
      elapsed_in = elapsed_ff;
      priority if (close) begin
         // a pulse on the closing beat opens the new window
         elapsed_in = '0;
         count_in   = COUNT_WIDTH'(req_pulse_edge);
      end else if (accept) begin
         if (req_time_tick) begin
            elapsed_in = elapsed_inc;
         end
         // hold at the counter maximum
         if (req_pulse_edge && !(&count_ff)) begin
            count_in = count_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         elapsed_ff <= '0;
      end else begin
         count_ff   <= count_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

// ===== rtl/core/prws_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prws_back
// Evaluates the calibration polynomial for one pulse count on a shared
// multiplier, applies the calm threshold, converts to km/h and holds the
// result beat until it is taken.
// ----------------------------------------------------------------------------
`include "pulse_rate_wind_speed_macros.svh"
module prws_back #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  prws_pkg::coef_type                  coef,
   input  logic                                q_empty,
   input  logic [COUNT_WIDTH-1:0]              q_data,
   output logic                                q_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [prws_pkg::PCOUNT_W-1:0]       rsp_pulse_count,
   output logic [prws_pkg::SPEED_W-1:0]        rsp_speed_mps,
   output logic [prws_pkg::SPEED_W-1:0]        rsp_speed_kmph
);

   localparam int CW = COUNT_WIDTH;
   localparam int UW = CW + 33;      // a*n + b
   localparam int MW = CW + 34;      // multiplier product
   localparam int PW = 2 * CW + 33;  // (a*n + b) * n
   localparam int VW = PW + 1;       // plus offset
   localparam int HW = UW - 32;      // upper slice of a*n + b
   localparam int DW = prws_pkg::KMPH_W;

   localparam logic signed [VW-1:0] MPS_LIMIT =
      VW'($signed({1'b0, prws_pkg::SPEED_MAX}));

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_ADD_B,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_OFFSET,
      ST_CLAMP,
      ST_PREP,
      ST_DSUM,
      ST_REM,
      ST_DIV,
      ST_WRITE
   } state_type;

   state_type                           state_ff;
   logic [CW-1:0]                       n_ff;
   logic signed [MW-1:0]                mul_ff;
   logic signed [MW-1:0]                lo_ff;
   logic signed [UW-1:0]                u_ff;
   logic signed [PW-1:0]                p_ff;
   logic signed [VW-1:0]                v_ff;
   logic [prws_pkg::SPEED_W-1:0]        mps_ff;
   logic [DW-1:0]                       sr_ff;
   logic [7:0]                          dsum_ff;
   logic                                over_ff;
   logic [prws_pkg::SPEED_W-1:0]        num_ff;
   logic [prws_pkg::SPEED_W-1:0]        kmph_ff;
   logic                                rsp_valid_ff;
   logic [prws_pkg::PCOUNT_W-1:0]       cnt_out_ff;
   logic [prws_pkg::SPEED_W-1:0]        mps_out_ff;
   logic [prws_pkg::SPEED_W-1:0]        kmph_out_ff;

   logic signed [32:0]                  mul_x;
   logic signed [CW:0]                  mul_y;
   logic signed [MW-1:0]                mul_p;
   logic signed [VW-1:0]                calm_v;
   logic [7:0]                          dsum_w;
   logic [4:0]                          fold_w;
   logic [2:0]                          rem_w;
   logic                                load;
   logic [prws_pkg::PCOUNT_W-1:0]       cnt_w;

   assign q_pop           = (state_ff == ST_IDLE) && !q_empty;
   assign load            = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_pop);
   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_pulse_count = cnt_out_ff;
   assign rsp_speed_mps   = mps_out_ff;
   assign rsp_speed_kmph  = kmph_out_ff;
   assign calm_v          = VW'($signed({1'b0, coef.calm}));

   // shared multiplier: signed 33 bits by the unsigned count
   assign mul_y = $signed({1'b0, n_ff});
   assign mul_p = mul_x * mul_y;

   always_comb begin
      unique case (state_ff)
         ST_MUL_A:  mul_x = {coef.square[31], coef.square};
         ST_MUL_LO: mul_x = {1'b0, u_ff[31:0]};
         ST_MUL_HI: mul_x = {{(33 - HW){u_ff[UW-1]}}, u_ff[UW-1:32]};
         default:   mul_x = '0;
      endcase
   end

   // nibble sum keeps the value modulo five
   always_comb begin
      dsum_w = '0;
      for (int i = 0; i < prws_pkg::NIBBLES; i++) begin
         dsum_w = dsum_w + 8'(sr_ff[4*i +: 4]);
      end
   end

   assign fold_w = 5'(dsum_ff[7:4]) + 5'(dsum_ff[3:0]);

   always_comb begin
      priority if (fold_w >= 5'd20) begin
         rem_w = 3'(fold_w - 5'd20);
      end else if (fold_w >= 5'd15) begin
         rem_w = 3'(fold_w - 5'd15);
      end else if (fold_w >= 5'd10) begin
         rem_w = 3'(fold_w - 5'd10);
      end else if (fold_w >= 5'd5) begin
         rem_w = 3'(fold_w - 5'd5);
      end else begin
         rem_w = fold_w[2:0];
      end
   end

   assign cnt_w  = (n_ff > CW'(prws_pkg::PCOUNT_MAX)) ? prws_pkg::PCOUNT_MAX
                                                     : prws_pkg::PCOUNT_W'(n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  n_ff     <= q_data;
                  state_ff <= ST_MUL_A;
               end
            end
            ST_MUL_A: begin
               mul_ff   <= mul_p;
               state_ff <= ST_ADD_B;
            end
            ST_ADD_B: begin
               u_ff     <= mul_ff[UW-1:0] + {{(UW - 32){coef.linear[31]}}, coef.linear};
               state_ff <= ST_MUL_LO;
            end
            ST_MUL_LO: begin
               lo_ff    <= mul_p;
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               mul_ff   <= mul_p;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               p_ff     <= (PW'(mul_ff) <<< 32) + PW'(lo_ff);
               state_ff <= ST_OFFSET;
            end
            ST_OFFSET: begin
               v_ff     <= VW'(p_ff) + VW'(coef.offset);
               state_ff <= ST_CLAMP;
            end
            ST_CLAMP: begin
               // calm covers every negative value too
               priority if (v_ff <= calm_v) begin
                  mps_ff <= '0;
               end else if (v_ff > MPS_LIMIT) begin
                  mps_ff <= prws_pkg::SPEED_MAX;
               end else begin
                  mps_ff <= v_ff[prws_pkg::SPEED_W-1:0];
               end
               state_ff <= ST_PREP;
            end
            ST_PREP: begin
               // 18 * mps + 2, rounds the divide to nearest
               sr_ff    <= DW'({mps_ff, 4'b0000}) + DW'({mps_ff, 1'b0}) + DW'(2);
               state_ff <= ST_DSUM;
            end
            ST_DSUM: begin
               dsum_ff  <= dsum_w;
               over_ff  <= (sr_ff >= prws_pkg::KMPH_OVER);
               state_ff <= ST_REM;
            end
            ST_REM: begin
               // drop the remainder so the divide is exact
               num_ff   <= sr_ff[prws_pkg::SPEED_W-1:0] - prws_pkg::SPEED_W'(rem_w);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               kmph_ff  <= over_ff ? prws_pkg::SPEED_MAX : num_ff * prws_pkg::INV_FIVE;
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               if (load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cnt_out_ff  <= cnt_w;
         mps_out_ff  <= mps_ff;
         kmph_out_ff <= kmph_ff;
      end
   end

   `PRWS_ASSERT(a_kmph_ge_mps, clock, reset, rsp_valid_ff |-> (kmph_out_ff >= mps_out_ff))
   `PRWS_ASSERT(a_calm_kmph, clock, reset, rsp_valid_ff && mps_out_ff == '0 |-> kmph_out_ff == '0)
   `PRWS_ASSERT(a_write_lands, clock, reset, ((state_ff == ST_WRITE) && !rsp_valid_ff) |=> rsp_valid_ff)

endmodule
